// ===== rtl/dap_pkg.sv =====
// Shared types, constants and power-of-ten table for the decimal amount parser.
// No dependencies; used by every module of the block.
`default_nettype none

package dap_pkg;

  localparam int FRACTION_DIGITS_DEF = 10;
  localparam int POW_W = 5;

  localparam logic [63:0] AMOUNT_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;

  localparam logic [15:0] CU_DOT  = 16'h002E;
  localparam logic [15:0] CU_ZERO = 16'h0030;
  localparam logic [15:0] CU_NINE = 16'h0039;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [15:0] code_unit;
  } in_item_t;

  typedef struct packed {
    logic        valid_res;
    logic [62:0] amount_units;
  } out_item_t;

  // one character or end marker handed to the accumulator
  typedef struct packed {
    logic     en;
    in_item_t item;
  } step_t;

  function automatic logic [63:0] pow10(input logic [POW_W-1:0] n);
    logic [63:0] p;
    case (n)
      5'd0:    p = 64'd1;
      5'd1:    p = 64'd10;
      5'd2:    p = 64'd100;
      5'd3:    p = 64'd1000;
      5'd4:    p = 64'd10000;
      5'd5:    p = 64'd100000;
      5'd6:    p = 64'd1000000;
      5'd7:    p = 64'd10000000;
      5'd8:    p = 64'd100000000;
      5'd9:    p = 64'd1000000000;
      5'd10:   p = 64'd10000000000;
      5'd11:   p = 64'd100000000000;
      5'd12:   p = 64'd1000000000000;
      5'd13:   p = 64'd10000000000000;
      5'd14:   p = 64'd100000000000000;
      5'd15:   p = 64'd1000000000000000;
      5'd16:   p = 64'd10000000000000000;
      5'd17:   p = 64'd100000000000000000;
      5'd18:   p = 64'd1000000000000000000;
      default: p = 64'd0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/dap_accum.sv =====
// Parse state and per-character update; forms the result for an end marker.
// Depends on dap_pkg.
`default_nettype none

module dap_accum #(
  parameter int FRAC_DIGITS = dap_pkg::FRACTION_DIGITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire dap_pkg::step_t     step,
  output dap_pkg::out_item_t      res
);

  localparam logic [63:0] SCALE = dap_pkg::pow10(dap_pkg::POW_W'(FRAC_DIGITS));
  localparam logic [63:0] MAX_WHOLE = dap_pkg::AMOUNT_LIMIT / SCALE;
  localparam logic [63:0] MAX_WHOLE_DIV10 = MAX_WHOLE / 10;
  localparam int WHOLE_W = $clog2(MAX_WHOLE + 64'd1);
  localparam int FRAC_W  = $clog2(SCALE);
  localparam int CNT_W   = $clog2(FRAC_DIGITS + 1);

  logic [WHOLE_W-1:0] whole_r, whole_nxt;
  logic [62:0]        wscaled_r, wscaled_nxt;
  logic [FRAC_W-1:0]  frac_r, frac_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               dot_r, dot_nxt;
  logic               nonempty_r, nonempty_nxt;
  logic               rej_r, rej_nxt;

  logic [3:0]              digit;
  logic                    is_digit;
  logic [WHOLE_W+3:0]      whole_new;
  logic [63:0]             wscaled_new;
  logic [dap_pkg::POW_W-1:0] frac_exp;
  logic [63:0]             frac_add;
  logic [63:0]             total;
  logic                    ok;

  assign digit    = step.item.code_unit[3:0];
  assign is_digit = step.item.code_unit inside {[dap_pkg::CU_ZERO:dap_pkg::CU_NINE]};

  // whole*10 + d, and the same on the value already scaled by 10^FRAC_DIGITS
  assign whole_new = ((WHOLE_W+4)'(whole_r) << 3) + ((WHOLE_W+4)'(whole_r) << 1)
                   + (WHOLE_W+4)'(digit);
  assign wscaled_new = (64'(wscaled_r) << 3) + (64'(wscaled_r) << 1)
                     + 64'(digit) * SCALE;

  // place the fraction digit at its final weight
  assign frac_exp = dap_pkg::POW_W'(FRAC_DIGITS - 1) - dap_pkg::POW_W'(cnt_r);
  assign frac_add = 64'(digit) * dap_pkg::pow10(frac_exp);

  always_comb begin
    whole_nxt    = whole_r;
    wscaled_nxt  = wscaled_r;
    frac_nxt     = frac_r;
    cnt_nxt      = cnt_r;
    dot_nxt      = dot_r;
    nonempty_nxt = nonempty_r;
    rej_nxt      = rej_r;
    if (step.en) begin
      if (step.item.kind == dap_pkg::KIND_END) begin
        whole_nxt    = '0;
        wscaled_nxt  = '0;
        frac_nxt     = '0;
        cnt_nxt      = '0;
        dot_nxt      = 1'b0;
        nonempty_nxt = 1'b0;
        rej_nxt      = 1'b0;
      end else if (!rej_r) begin
        if (step.item.code_unit == dap_pkg::CU_DOT && !dot_r) begin
          dot_nxt = 1'b1;
        end else if (!is_digit) begin
          rej_nxt = 1'b1;
        end else if (!dot_r) begin
          if (64'(whole_r) > MAX_WHOLE_DIV10) begin
            rej_nxt = 1'b1;
          end else if (64'(whole_new) > MAX_WHOLE) begin
            rej_nxt = 1'b1;
          end else begin
            whole_nxt    = WHOLE_W'(whole_new);
            wscaled_nxt  = wscaled_new[62:0];
            nonempty_nxt = 1'b1;
          end
        end else begin
          if (cnt_r >= CNT_W'(FRAC_DIGITS)) begin
            rej_nxt = 1'b1;
          end else begin
            frac_nxt = frac_r + FRAC_W'(frac_add);
            cnt_nxt  = cnt_r + CNT_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      whole_r    <= '0;
      wscaled_r  <= '0;
      frac_r     <= '0;
      cnt_r      <= '0;
      dot_r      <= 1'b0;
      nonempty_r <= 1'b0;
      rej_r      <= 1'b0;
    end else begin
      whole_r    <= whole_nxt;
      wscaled_r  <= wscaled_nxt;
      frac_r     <= frac_nxt;
      cnt_r      <= cnt_nxt;
      dot_r      <= dot_nxt;
      nonempty_r <= nonempty_nxt;
      rej_r      <= rej_nxt;
    end
  end

  // result from the state left by all characters before the end marker
  assign total = 64'(wscaled_r) + 64'(frac_r);
  assign ok    = !rej_r && (nonempty_r || cnt_r != '0) && !total[63];

  always_comb begin
    res.valid_res    = ok;
    res.amount_units = ok ? total[62:0] : 63'd0;
  end

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step.en && step.item.kind == dap_pkg::KIND_END
    |=> !rej_r && !dot_r && !nonempty_r && cnt_r == '0)
    else $error("parse state not cleared after end marker");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(FRAC_DIGITS))
    else $error("fraction digit count beyond limit");

endmodule

`default_nettype wire

// ===== rtl/dap_out_reg.sv =====
// Result register of the decimal amount parser; holds one result until taken.
// Depends on dap_pkg.
`default_nettype none

module dap_out_reg (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                load,
  input  wire dap_pkg::out_item_t  load_data,
  output logic                     free,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output dap_pkg::out_item_t       out_data
);

  logic               vld_r, vld_nxt;
  dap_pkg::out_item_t data_r;

  assign free = !vld_r || out_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = vld_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

// ===== rtl/decimal_amount_parser.sv =====
// Decimal amount parser: one UTF-16 code unit per transaction, end marker emits result.
// An end marker's result is registered as the marker leaves the input register.
// Throughput: one item per cycle unless an end marker waits; each character folds in
// through a single multiply-by-ten, add and compare step on the registered parse state.
// An end marker waits in the input register only while the result register is held.
// Reset (rst_n low, synchronous) clears the parse state and both valid flags.
`default_nettype none

module decimal_amount_parser #(
  parameter int FRAC_DIGITS = dap_pkg::FRACTION_DIGITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire dap_pkg::in_item_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output dap_pkg::out_item_t       out_data
);

  logic               in_vld_r, in_vld_nxt;
  dap_pkg::in_item_t  in_item_r;
  logic               out_free;
  logic               advance;
  logic               load_res;
  dap_pkg::step_t     step;
  dap_pkg::out_item_t res;

  // characters never wait; an end marker needs room in the result register
  assign advance  = in_vld_r && (in_item_r.kind == dap_pkg::KIND_CHAR || out_free);
  assign in_ready = !in_vld_r || advance;
  assign load_res = advance && in_item_r.kind == dap_pkg::KIND_END;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_valid && in_ready) begin
      in_vld_nxt = 1'b1;
    end else if (advance) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_data;
    end
  end

  always_comb begin
    step.en   = advance;
    step.item = in_item_r;
  end

  dap_accum #(
    .FRAC_DIGITS(FRAC_DIGITS)
  ) u_accum (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .res   (res)
  );

  dap_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load_res),
    .load_data (res),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    load_res |=> out_valid)
    else $error("end marker did not produce a result");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && !load_res |=> !out_valid)
    else $error("result appeared without an end marker");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> in_vld_r && in_item_r.kind == dap_pkg::KIND_END && out_valid && !out_ready)
    else $error("input stalled without a held result");

endmodule

`default_nettype wire
